FILE: design/minmax_intensity_rescale_core_defines.svh
// Assertion macros for the min/max intensity rescale core.
// Depends on nothing; expects signals clk and rst_n in the including module.
`ifndef MINMAX_INTENSITY_RESCALE_CORE_DEFINES_SVH
`define MINMAX_INTENSITY_RESCALE_CORE_DEFINES_SVH

// Same-cycle property, checked on every rising edge outside reset.
`define MMIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define MMIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mmir_pkg.sv
// Shared types and constants for the min/max intensity rescale core.
// No dependencies.
package mmir_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_W       = 16;
    localparam int OUT_W       = 24;

    // clamped sample, tracked min/max and range are non-negative
    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int PROD_W = MAG_W + CFG_W;
    localparam int DVD_W  = PROD_W + FRAC_BITS;
    localparam int SUM_W  = DVD_W + 2;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b1;

    localparam logic signed [CFG_W-1:0] LOWER_RST = CFG_W'(0);
    localparam logic signed [CFG_W-1:0] UPPER_RST = CFG_W'(255);

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] scaled;
        logic                    flat;
    } result_t;

endpackage

FILE: design/minmax_intensity_rescale_core.sv
// Min/max intensity rescale core: scan/map voxel rescaler with a serial divider.
// Depends on mmir_pkg and minmax_intensity_rescale_core_defines.svh.
//
// Each voxel is sent twice. A scan transaction (action 0) clamps negative
// samples to zero and updates the running minimum and maximum; first = 1
// restarts both at the sample. A scan transaction does not stall and yields
// no result. A map transaction (action 1) yields one result: lower*2^F plus
// the truncated quotient of (x-min)*(upper-lower)*2^F by (max-min), saturated
// to 24 bits, with flat = 1 and the plain lower*2^F when max <= min. A map
// transaction passes through the multiply step, the restoring divider that
// retires one quotient bit per cycle, the final add and the output load,
// with the input stalled after its accept until the output register is loaded.
// A flat map transaction skips multiply and divide. The load step waits,
// and the input stays stalled, for as long as an earlier result is still
// held in the output register by result_stall. The result sits in an output
// register, so the next transaction is accepted while a result still waits
// downstream. The user must write bounds through the cfg port only while
// the core is idle; the core itself does not enforce this.
`include "minmax_intensity_rescale_core_defines.svh"

module minmax_intensity_rescale_core
    import mmir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (OUT_W - 1));

    // control and configuration
    logic [2:0]              state_reg, state_next;
    logic signed [CFG_W-1:0] lower_reg, lower_next;
    logic signed [CFG_W-1:0] upper_reg, upper_next;
    logic [MAG_W-1:0]        run_min_reg, run_min_next;
    logic [MAG_W-1:0]        run_max_reg, run_max_next;
    logic                    res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // datapath
    logic [MAG_W-1:0]        dmag_reg, dmag_next;
    logic [CFG_W-1:0]        rmag_reg, rmag_next;
    logic [MAG_W-1:0]        den_reg, den_next;
    logic [MAG_W-1:0]        rem_reg, rem_next;
    logic [DVD_W-1:0]        quo_reg, quo_next;
    logic                    neg_reg, neg_next;
    logic                    flat_reg, flat_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    result_t                 res_reg, res_next;

    logic                    item_take;
    logic [MAG_W-1:0]        x_clamp;
    logic signed [MAG_W:0]   d_diff;
    logic signed [CFG_W:0]   r_diff;
    logic [MAG_W:0]          trial;
    logic [PROD_W-1:0]       prod;
    logic signed [SUM_W-1:0] base_ext;
    logic signed [SUM_W-1:0] q_signed;
    logic signed [OUT_W-1:0] sat_val;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign x_clamp  = item.sample[SAMPLE_BITS-1] ? '0 : item.sample[MAG_W-1:0];
    assign d_diff   = $signed({1'b0, x_clamp}) - $signed({1'b0, run_min_reg});
    assign r_diff   = $signed({upper_reg[CFG_W-1], upper_reg})
                    - $signed({lower_reg[CFG_W-1], lower_reg});
    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign prod     = PROD_W'(dmag_reg) * PROD_W'(rmag_reg);
    assign base_ext = $signed({{(SUM_W-CFG_W){lower_reg[CFG_W-1]}}, lower_reg}) <<< FRAC_BITS;
    assign q_signed = neg_reg ? -$signed(SUM_W'(quo_reg)) : $signed(SUM_W'(quo_reg));

    always_comb
    begin
        if (sum_reg > SAT_HI)
        begin
            sat_val = SAT_HI[OUT_W-1:0];
        end
        else if (sum_reg < SAT_LO)
        begin
            sat_val = SAT_LO[OUT_W-1:0];
        end
        else
        begin
            sat_val = sum_reg[OUT_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        res_valid_next = res_valid_reg;
        cnt_next       = cnt_reg;
        dmag_next      = dmag_reg;
        rmag_next      = rmag_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        flat_next      = flat_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOWER: lower_next = $signed(cfg_data);
                REG_UPPER: upper_next = $signed(cfg_data);
                default:   ;
            endcase
        end

        // downstream took the result
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take && !item.action)
                begin
                    if (item.first)
                    begin
                        run_min_next = x_clamp;
                        run_max_next = x_clamp;
                    end
                    else
                    begin
                        if (x_clamp < run_min_reg)
                        begin
                            run_min_next = x_clamp;
                        end
                        if (x_clamp > run_max_reg)
                        begin
                            run_max_next = x_clamp;
                        end
                    end
                end
                else if (item_take)
                begin
                    flat_next = (run_max_reg <= run_min_reg);
                    dmag_next = d_diff[MAG_W] ? MAG_W'(-d_diff) : d_diff[MAG_W-1:0];
                    rmag_next = r_diff[CFG_W] ? CFG_W'(-r_diff) : r_diff[CFG_W-1:0];
                    neg_next  = d_diff[MAG_W] ^ r_diff[CFG_W];
                    den_next  = run_max_reg - run_min_reg;
                    if (run_max_reg <= run_min_reg)
                    begin
                        quo_next   = '0;
                        neg_next   = 1'b0;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                quo_next   = DVD_W'(prod) << FRAC_BITS;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring step: one quotient bit shifted in per cycle
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = MAG_W'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[MAG_W-1:0];
                    quo_next = {quo_reg[DVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                sum_next   = base_ext + q_signed;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next.scaled = sat_val;
                    res_next.flat   = flat_reg;
                    res_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lower_reg     <= LOWER_RST;
            upper_reg     <= UPPER_RST;
            run_min_reg   <= '1;
            run_max_reg   <= '0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg <= dmag_next;
        rmag_reg <= rmag_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        flat_reg <= flat_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

    // a new result appears only out of the output-load step
    `MMIR_ASSERT(a_load_from_out, (result_valid && !$past(result_valid)) |-> ($past(state_reg) == ST_OUT), "result loaded outside output step")
    // divider never runs past its last quotient bit
    `MMIR_ASSERT(a_cnt_range, (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(DVD_W - 1)), "divider count out of range")
    // partial remainder stays below the range
    `MMIR_ASSERT(a_rem_below_den, (state_reg == ST_DIV) |-> (rem_reg < den_reg), "remainder not below divisor")
    // a map transaction holds off the input on the next cycle
    `MMIR_ASSERT_NEXT(a_map_busy, item_take && item.action, item_stall, "map transaction did not occupy the core")

endmodule
